// ----- rtl/core/sdmd_pkg.sv -----
// Package for the sigma-delta motion detector: field widths, constants, helpers.
package sdmd_pkg;

    localparam int IDX_W = 14;  // pixel index field
    localparam int PIX_W = 8;   // grey level, background and variance width
    localparam int CMP_W = 21;  // wide enough for any frame size up to 2^20 pixels

    localparam logic [PIX_W-1:0] GAIN_RESET = 8'd3;
    localparam logic [PIX_W-1:0] VAR_INIT   = 8'd1;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'hFF;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [IDX_W-1:0] idx_t;

    // Move cur one step toward target.
    function automatic pix_t step_toward(input pix_t cur, input pix_t target);
        pix_t res;
        res = cur;
        if (cur < target) begin
            res = cur + 8'd1;
        end else if (cur > target) begin
            res = cur - 8'd1;
        end
        return res;
    endfunction

    // Absolute difference of two grey levels.
    function automatic pix_t abs_diff(input pix_t a, input pix_t b);
        pix_t res;
        res = (a > b) ? (a - b) : (b - a);
        return res;
    endfunction

endpackage

// ----- rtl/core/sigma_delta_motion_detector_top.sv -----
// Sigma-delta motion detector: per-pixel background/variance pipeline.
//
// Usage:
//  - Input channel s_*: one beat per pixel (index, grey level, first-frame flag).
//  - Result channel m_*: one beat per input beat, in order: echoed index and
//    foreground label (1 = moving pixel).
//  - Config channel cfg_*: writes the 8-bit gain; always ready. Write only
//    while no pixel is in flight.
//  - Throughput: one pixel per clock while the output is not stalled. Each
//    result passes stages 1, 2, 3 and the output register before m_valid.
//  - Pipeline: stage 1 holds the registered store read and steps the
//    background, stage 2 forms gain*d, stage 3 saturates, steps the variance,
//    labels and writes both stores. The write feeds younger beats of the
//    same pixel still in flight, so back-to-back hits on one pixel are exact.
//  - Stall: when m_ready is low and a result is waiting, the whole pipeline
//    and the store reads freeze; s_ready drops until the output moves.
//  - Reset (aresetn, synchronous, active low): pipeline emptied, gain = 3.
//    Stores are not cleared; a pixel must see a first-frame beat before use.
//  - Indexes at or above MAX_PIXELS pass through with label 0, no store update.
module sigma_delta_motion_detector_top #(
    parameter int MAX_PIXELS = 16384
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // pixel input
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sdmd_pkg::IDX_W-1:0] s_pixel_index,
    input  logic [sdmd_pkg::PIX_W-1:0] s_pixel_value,
    input  logic                       s_first_frame,
    // label output
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sdmd_pkg::IDX_W-1:0] m_result_index,
    output logic                       m_foreground,
    // gain register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sdmd_pkg::PIX_W-1:0] cfg_gain
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    typedef logic [ADDR_W-1:0] addr_t;

    // configuration
    sdmd_pkg::pix_t gain_reg;

    // pipeline control
    logic adv;

    // incoming beat
    addr_t s_addr;
    logic  s_inr;

    // stores
    sdmd_pkg::pix_t bg_mem  [MAX_PIXELS];
    sdmd_pkg::pix_t var_mem [MAX_PIXELS];
    sdmd_pkg::pix_t bgrd_reg, varrd_reg;

    // stage 1
    logic           v1_reg, first1_reg, inr1_reg, fwd1_reg;
    sdmd_pkg::idx_t idx1_reg;
    sdmd_pkg::pix_t pix1_reg, fbg1_reg, fvar1_reg;
    addr_t          addr1_reg;

    // stage 2
    logic           v2_reg, first2_reg, inr2_reg;
    sdmd_pkg::idx_t idx2_reg;
    sdmd_pkg::pix_t bg2_reg, d2_reg, var2_reg;
    addr_t          addr2_reg;

    // stage 3
    logic           v3_reg, first3_reg, inr3_reg;
    sdmd_pkg::idx_t idx3_reg;
    sdmd_pkg::pix_t bg3_reg, d3_reg, var3_reg;
    logic [2*sdmd_pkg::PIX_W-1:0] prod3_reg;
    addr_t          addr3_reg;

    // output stage
    logic           m_valid_reg, m_fg_reg;
    sdmd_pkg::idx_t m_idx_reg;

    // last store write, tracked for checking
    logic           lw_valid_reg;
    addr_t          lw_addr_reg;
    sdmd_pkg::pix_t lw_var_reg;

    // stage 1 logic
    logic           hit1_s2, hit1_s3;
    sdmd_pkg::pix_t bg_base1, var_base1, bg_cur1, bg_new1, d1, var1_next;

    // stage 2 logic
    logic           hit2_s3;
    logic [2*sdmd_pkg::PIX_W-1:0] prod2;

    // stage 3 logic
    sdmd_pkg::pix_t target3, var_new3;
    logic           fg3, wr_en, hit_s_s3;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_idx_reg;
    assign m_foreground   = m_fg_reg;

    // incoming address and range check
    assign s_inr = sdmd_pkg::CMP_W'(s_pixel_index) < sdmd_pkg::CMP_W'(MAX_PIXELS);
    generate
        if (ADDR_W <= sdmd_pkg::IDX_W) begin : g_addr_narrow
            assign s_addr = s_pixel_index[ADDR_W-1:0];
        end else begin : g_addr_wide
            assign s_addr = ADDR_W'(s_pixel_index);
        end
    endgenerate

    // stage 3: saturate product, step variance, label, write
    always_comb begin
        target3 = (prod3_reg[2*sdmd_pkg::PIX_W-1:sdmd_pkg::PIX_W] != '0)
                ? sdmd_pkg::PIX_MAX : prod3_reg[sdmd_pkg::PIX_W-1:0];
        if (first3_reg) begin
            var_new3 = sdmd_pkg::VAR_INIT;
        end else if (d3_reg != '0) begin
            var_new3 = sdmd_pkg::step_toward(var3_reg, target3);
        end else begin
            var_new3 = var3_reg;
        end
        fg3 = inr3_reg && !first3_reg && (d3_reg >= var_new3);
    end

    assign wr_en    = adv && v3_reg && inr3_reg;
    assign hit_s_s3 = v3_reg && inr3_reg && s_inr && (addr3_reg == s_addr);

    // stage 1: resolve background against older beats, step it, take |d|
    always_comb begin
        bg_base1  = fwd1_reg ? fbg1_reg  : bgrd_reg;
        var_base1 = fwd1_reg ? fvar1_reg : varrd_reg;
        hit1_s2   = v2_reg && inr2_reg && (addr2_reg == addr1_reg);
        hit1_s3   = v3_reg && inr3_reg && (addr3_reg == addr1_reg);
        if (hit1_s2) begin
            bg_cur1 = bg2_reg;
        end else if (hit1_s3) begin
            bg_cur1 = bg3_reg;
        end else begin
            bg_cur1 = bg_base1;
        end
        // variance of the stage 2 beat lands later, on the stage 2 -> 3 move
        var1_next = hit1_s3 ? var_new3 : var_base1;
        bg_new1   = first1_reg ? pix1_reg : sdmd_pkg::step_toward(bg_cur1, pix1_reg);
        d1        = sdmd_pkg::abs_diff(bg_new1, pix1_reg);
    end

    // stage 2: variance target product
    assign hit2_s3 = v3_reg && inr3_reg && (addr3_reg == addr2_reg);
    assign prod2   = (2*sdmd_pkg::PIX_W)'(gain_reg) * (2*sdmd_pkg::PIX_W)'(d2_reg);

    // stores: registered read, read-first on the same edge as a write
    always_ff @(posedge aclk) begin
        if (adv) begin
            bgrd_reg  <= bg_mem[s_addr];
            varrd_reg <= var_mem[s_addr];
        end
        if (wr_en) begin
            bg_mem[addr3_reg]  <= bg3_reg;
            var_mem[addr3_reg] <= var_new3;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg     <= sdmd_pkg::GAIN_RESET;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                gain_reg <= cfg_gain;
            end
            if (adv) begin
                v1_reg       <= s_valid;
                v2_reg       <= v1_reg;
                v3_reg       <= v2_reg;
                m_valid_reg  <= v3_reg;
                lw_valid_reg <= wr_en;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            idx1_reg   <= s_pixel_index;
            pix1_reg   <= s_pixel_value;
            first1_reg <= s_first_frame;
            inr1_reg   <= s_inr;
            addr1_reg  <= s_addr;
            fwd1_reg   <= hit_s_s3;
            fbg1_reg   <= bg3_reg;
            fvar1_reg  <= var_new3;

            idx2_reg   <= idx1_reg;
            first2_reg <= first1_reg;
            inr2_reg   <= inr1_reg;
            addr2_reg  <= addr1_reg;
            bg2_reg    <= bg_new1;
            d2_reg     <= d1;
            var2_reg   <= var1_next;

            idx3_reg   <= idx2_reg;
            first3_reg <= first2_reg;
            inr3_reg   <= inr2_reg;
            addr3_reg  <= addr2_reg;
            bg3_reg    <= bg2_reg;
            d3_reg     <= d2_reg;
            var3_reg   <= hit2_s3 ? var_new3 : var2_reg;
            prod3_reg  <= prod2;

            m_idx_reg  <= idx3_reg;
            m_fg_reg   <= fg3;

            lw_addr_reg <= addr3_reg;
            lw_var_reg  <= var_new3;
        end
    end

    // variance seen in stage 3 must match the write just made to the same pixel
    a_var_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && inr3_reg && !first3_reg && lw_valid_reg && (lw_addr_reg == addr3_reg))
        |-> (var3_reg == lw_var_reg))
        else $error("variance forwarding mismatch");

    // first-frame beats always come out as background
    a_first_bg: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v3_reg && first3_reg) |=> (m_valid && !m_foreground))
        else $error("first-frame pixel labelled foreground");

    // out-of-range beats never label and never write
    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v3_reg && !inr3_reg) |=> (m_valid && !m_foreground && !lw_valid_reg))
        else $error("out-of-range pixel touched stores or labelled");

    // gain comes out of reset at its default
    a_gain_rst: assert property (@(posedge aclk)
        !aresetn |=> (gain_reg == sdmd_pkg::GAIN_RESET))
        else $error("gain not at reset value");

endmodule

// ----- test/sdmd_label_checker.sv -----
// Checker for the motion detector: predicts each label and compares result beats.
`timescale 1ns / 100ps

module sdmd_label_checker #(
    parameter int MAX_PIXELS = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  sdmd_pkg::idx_t       s_pixel_index,
    input  sdmd_pkg::pix_t       s_pixel_value,
    input  logic                 s_first_frame,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  sdmd_pkg::idx_t       m_result_index,
    input  logic                 m_foreground,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  sdmd_pkg::pix_t       cfg_gain,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        sdmd_pkg::idx_t index;
        logic           foreground;
    } label_t;

    sdmd_pkg::pix_t bg_mem[MAX_PIXELS];
    sdmd_pkg::pix_t spread_mem[MAX_PIXELS];
    sdmd_pkg::pix_t gain_now;
    label_t         label_q[$];

    function automatic sdmd_pkg::pix_t nudge(input sdmd_pkg::pix_t cur,
                                             input sdmd_pkg::pix_t goal);
        if (cur < goal) begin
            return cur + 8'd1;
        end else if (cur > goal) begin
            return cur - 8'd1;
        end
        return cur;
    endfunction

    // Updates the per-pixel estimates and returns the label for one pixel beat.
    function automatic logic predict_label(input sdmd_pkg::idx_t idx,
                                           input sdmd_pkg::pix_t pix, input logic first);
        sdmd_pkg::pix_t bg;
        sdmd_pkg::pix_t spread;
        sdmd_pkg::pix_t d;
        sdmd_pkg::pix_t goal;
        logic [15:0]    prod;
        if (idx >= MAX_PIXELS) begin
            return 1'b0;
        end
        if (first) begin
            bg_mem[idx]     = pix;
            spread_mem[idx] = sdmd_pkg::VAR_INIT;
            return 1'b0;
        end
        bg     = nudge(bg_mem[idx], pix);
        spread = spread_mem[idx];
        d      = (bg > pix) ? bg - pix : pix - bg;
        prod   = 16'(gain_now) * 16'(d);
        goal   = (prod > sdmd_pkg::PIX_MAX) ? sdmd_pkg::PIX_MAX : prod[7:0];
        if (d != 8'd0) begin
            spread = nudge(spread, goal);
        end
        bg_mem[idx]     = bg;
        spread_mem[idx] = spread;
        return d >= spread;
    endfunction

    always @(posedge aclk) begin
        label_t want;
        if (!aresetn) begin
            gain_now   = sdmd_pkg::GAIN_RESET;
            fail_count = 0;
            label_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                gain_now = cfg_gain;
            end
            if (s_valid && s_ready) begin
                want.index      = s_pixel_index;
                want.foreground = predict_label(s_pixel_index, s_pixel_value, s_first_frame);
                label_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (label_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: index %0d, foreground %0d",
                             $time, m_result_index, m_foreground);
                end else begin
                    want = label_q.pop_front();
                    if (m_result_index !== want.index) begin
                        fail_count++;
                        $display("%0t: result_index mismatch: expected %0d, actual %0d",
                                 $time, want.index, m_result_index);
                    end
                    if (m_foreground !== want.foreground) begin
                        fail_count++;
                        $display("%0t: foreground mismatch (index %0d): expected %0d, actual %0d",
                                 $time, want.index, want.foreground, m_foreground);
                    end
                end
            end
        end
        pending = label_q.size();
    end

endmodule

// ----- test/tb_sigma_delta_motion_detector_top.sv -----
// Testbench top for the motion detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_sigma_delta_motion_detector_top;

    localparam int PIXELS        = 16384;
    localparam int POOL_N        = 24;    // pixels revisited often, so estimates settle
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int STALL_LIMIT   = 1000;  // cycles without any beat before giving up
    localparam int SETTLE_CYCLES = 20;    // longer than the pipeline latency, catches stray results

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    sdmd_pkg::idx_t s_pixel_index;
    sdmd_pkg::pix_t s_pixel_value;
    logic           s_first_frame;
    logic           m_valid;
    logic           m_ready;
    sdmd_pkg::idx_t m_result_index;
    logic           m_foreground;
    logic           cfg_valid;
    logic           cfg_ready;
    sdmd_pkg::pix_t cfg_gain;

    int   fail_count;
    int   pending;
    int   stall_cycles;

    // Per-side idle switch; phases turn them off to get back-to-back stretches.
    bit   idle_send;
    bit   idle_recv;

    // Stimulus bookkeeping: which pixels have seen a first-frame beat, last
    // value sent per pixel, the hot pool, and the previous index.
    bit                         primed[PIXELS];
    bit [sdmd_pkg::PIX_W-1:0]   last_val[PIXELS];
    sdmd_pkg::idx_t             pool[POOL_N];
    sdmd_pkg::idx_t             prev_idx;
    sdmd_pkg::pix_t             phase_gain[PHASES];

    sigma_delta_motion_detector_top #(
        .MAX_PIXELS(PIXELS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_index  (s_pixel_index),
        .s_pixel_value  (s_pixel_value),
        .s_first_frame  (s_first_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_index (m_result_index),
        .m_foreground   (m_foreground),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_gain       (cfg_gain)
    );

    sdmd_label_checker #(
        .MAX_PIXELS(PIXELS)
    ) label_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_index  (s_pixel_index),
        .s_pixel_value  (s_pixel_value),
        .s_first_frame  (s_first_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_index (m_result_index),
        .m_foreground   (m_foreground),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_gain       (cfg_gain),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("sigma_delta_motion_detector_top verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: while idle_recv is set, m_ready may drop low before each beat;
    // it then stays high until a beat goes through. Changes only at falling edges.
    initial begin
        int gap;
        m_ready <= 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            gap = idle_recv ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // One pixel beat. Entered at a falling edge, returns at the falling edge
    // after acceptance with s_valid still high: the next call either replaces
    // the payload or drops valid, so valid is never toggled within one step.
    task automatic send_pixel(input sdmd_pkg::idx_t idx, input sdmd_pkg::pix_t pix,
                              input logic first);
        int gap;
        gap = idle_send ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_index <= idx;
        s_pixel_value <= pix;
        s_first_frame <= first;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (first) begin
            primed[idx] = 1'b1;
        end
        last_val[idx] = pix;
        prev_idx      = idx;
    endtask

    // Drop valid and hold off until every predicted label has come back.
    task automatic drain;
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Gain write; only called with the pipeline empty.
    task automatic write_gain(input sdmd_pkg::pix_t g);
        cfg_valid <= 1'b1;
        cfg_gain  <= g;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic. Mostly repeat hits on the hot pool (and back-to-back
    // hits on one pixel) so background and variance walk far from their
    // initial values; a few first-frame beats land anywhere in the frame.
    // A pixel is never read before its first-frame beat.
    task automatic run_phase(input int n);
        int             k;
        int             roll;
        int             near;
        sdmd_pkg::idx_t idx;
        sdmd_pkg::pix_t pix;
        logic           first;
        for (k = 0; k < n; k++) begin
            // occasional full hold-off mid-phase
            if ($urandom_range(0, 99) == 0) begin
                drain;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                idx   = sdmd_pkg::idx_t'($urandom_range(0, PIXELS - 1));
                first = 1'b1;
                pool[$urandom_range(0, POOL_N - 1)] = idx;
            end else begin
                idx   = (roll < 28) ? prev_idx : pool[$urandom_range(0, POOL_N - 1)];
                first = !primed[idx] || ($urandom_range(0, 99) < 4);
            end
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                // small moves keep d low so labels go both ways
                near = int'(last_val[idx]) + int'($urandom_range(0, 6)) - 3;
                pix  = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : sdmd_pkg::pix_t'(near);
            end else if (roll < 75) begin
                pix = sdmd_pkg::pix_t'($urandom_range(0, 255));
            end else if (roll < 83) begin
                pix = 8'd0;
            end else if (roll < 91) begin
                pix = sdmd_pkg::PIX_MAX;
            end else begin
                pix = last_val[idx];
            end
            send_pixel(idx, pix, first);
        end
    endtask

    initial begin
        int p;
        int k;
        idle_send = 1'b1;
        idle_recv = 1'b1;
        prev_idx  = '0;
        s_valid       <= 1'b0;
        s_pixel_index <= '0;
        s_pixel_value <= '0;
        s_first_frame <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_gain      <= '0;
        aresetn       <= 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, at the reset gain of 3.
        // Extremes of index and value, first-frame init of both corners.
        send_pixel(14'd0,     8'd0,   1'b1);
        send_pixel(14'h3FFF,  8'd255, 1'b1);
        // full-scale jump: gain*d far above 255, saturates
        send_pixel(14'd0,     8'd255, 1'b0);
        send_pixel(14'h3FFF,  8'd0,   1'b0);
        // background meets the pixel: d = 0 leaves the variance alone
        send_pixel(14'd0,     8'd1,   1'b0);
        send_pixel(14'd0,     8'd1,   1'b0);
        // back-to-back hits on one pixel through the pipeline
        send_pixel(14'd0,     8'd200, 1'b0);
        send_pixel(14'd0,     8'd200, 1'b0);
        send_pixel(14'd0,     8'd200, 1'b0);
        send_pixel(14'd0,     8'd3,   1'b0);
        // alternating index and value bit patterns
        send_pixel(14'h2AAA,  8'hAA,  1'b1);
        send_pixel(14'h1555,  8'h55,  1'b1);
        send_pixel(14'h2AAA,  8'h55,  1'b0);
        send_pixel(14'h1555,  8'hAA,  1'b0);
        send_pixel(14'h2AAA,  8'hAA,  1'b0);
        // re-init a pixel that already has history, then small steps
        send_pixel(14'h3FFF,  8'd255, 1'b1);
        send_pixel(14'h3FFF,  8'd254, 1'b0);
        send_pixel(14'h3FFF,  8'd250, 1'b0);
        send_pixel(14'h3FFF,  8'd250, 1'b0);
        drain;

        pool[0] = 14'd0;
        pool[1] = 14'h3FFF;
        for (k = 2; k < POOL_N; k++) begin
            pool[k] = sdmd_pkg::idx_t'($urandom_range(0, PIXELS - 1));
        end

        // Gain sweep: zero (variance decays toward 0, labels lean to foreground), full scale,
        // unity, two random, and back to the reset value.
        phase_gain[0] = 8'd0;
        phase_gain[1] = sdmd_pkg::PIX_MAX;
        phase_gain[2] = 8'd1;
        phase_gain[3] = sdmd_pkg::pix_t'($urandom_range(0, 255));
        phase_gain[4] = sdmd_pkg::pix_t'($urandom_range(0, 255));
        phase_gain[5] = sdmd_pkg::GAIN_RESET;

        for (p = 0; p < PHASES; p++) begin
            write_gain(phase_gain[p]);
            idle_send = (p != 1) && (p != 4);
            idle_recv = (p != 1) && (p != 2);
            run_phase(PHASE_ITEMS);
            drain;
        end

        // let any stray beat surface before the verdict
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("sigma_delta_motion_detector_top verification clean");
        end else begin
            $display("sigma_delta_motion_detector_top verification failed");
        end
        $finish;
    end

endmodule
